// File: design/fbf_pkg.sv
// Shared constants and types of the fingerprint Bloom filter.
package fbf_pkg;

  localparam logic [31:0] C1     = 32'hcc9e2d51;
  localparam logic [31:0] C2     = 32'h1b873593;
  localparam logic [31:0] C3     = 32'he6546b64;
  localparam logic [31:0] C4     = 32'h85ebca6b;
  localparam logic [31:0] C5     = 32'hc2b2ae35;
  localparam logic [31:0] SEED_A = 32'haaaaaaaa;
  localparam logic [31:0] SEED_B = 32'hbbbbbbbb;

  localparam logic [1:0] ANS_INSERTED = 2'd0;
  localparam logic [1:0] ANS_FULL     = 2'd1;
  localparam logic [1:0] ANS_MAYBE    = 2'd2;
  localparam logic [1:0] ANS_ABSENT   = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;

  localparam logic [1:0] REG_CELLS  = 2'd0;
  localparam logic [1:0] REG_HASHES = 2'd1;
  localparam logic [1:0] REG_PROBES = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] key_word;
    logic [2:0]  word_bytes;
    logic        last_word;
  } word_t;

  typedef struct packed {
    logic        action;
    logic [31:0] ha;
    logic [31:0] hb;
  } job_t;

  typedef struct packed {
    logic [1:0]  answer;
    logic [31:0] element_count;
  } result_t;

  typedef struct packed {
    logic [12:0] cells;
    logic [3:0]  hashes;
    logic [4:0]  probes;
  } cfg_t;

endpackage

// File: design/fbf_if.sv
// Channel interfaces of the fingerprint Bloom filter.
interface fbf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] key_word;
  logic [2:0]  word_bytes;
  logic        last_word;
  modport source (output valid, action, key_word, word_bytes, last_word, input ready);
  modport sink (input valid, action, key_word, word_bytes, last_word, output ready);
endinterface

interface fbf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  answer;
  logic [31:0] element_count;
  modport source (output valid, answer, element_count, input ready);
  modport sink (input valid, answer, element_count, output ready);
endinterface

interface fbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/fbf_ram.sv
// Generic single write port RAM with registered read.
module fbf_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/fbf_front.sv
// Key hashing front: absorbs key words and finalizes both hashes.
module fbf_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         acc_i,
  input  fbf_pkg::word_t word_i,
  output logic         ready_o,
  output fbf_pkg::job_t job_o,
  output logic         job_valid_o,
  input  logic         job_ready_i
);
  typedef enum logic [2:0] {
    F_IDLE, F_M1, F_M2, F_M3, F_FIN1, F_FIN2, F_PUSH
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] ha_q, ha_d, hb_q, hb_d, k_q, k_d;
  logic [15:0] len_q, len_d;
  logic        act_q, act_d, full_q, full_d, last_q, last_d;

  always_comb begin
    logic [2:0]  n;
    logic [31:0] mask, ra, rb, fa, fb, kr;
    state_d = state_q;
    ha_d = ha_q;
    hb_d = hb_q;
    k_d = k_q;
    len_d = len_q;
    act_d = act_q;
    full_d = full_q;
    last_d = last_q;
    n = (word_i.word_bytes > 3'd4) ? 3'd4 : word_i.word_bytes;
    case (n)
      3'd1: mask = 32'h000000ff;
      3'd2: mask = 32'h0000ffff;
      3'd3: mask = 32'h00ffffff;
      default: mask = 32'hffffffff;
    endcase
    kr = {k_q[16:0], k_q[31:17]};
    ra = ha_q ^ k_q;
    rb = hb_q ^ k_q;
    ra = {ra[18:0], ra[31:19]};
    rb = {rb[18:0], rb[31:19]};
    fa = ha_q ^ {16'd0, len_q};
    fb = hb_q ^ {16'd0, len_q};
    fa = fa ^ (fa >> 16);
    fb = fb ^ (fb >> 16);
    unique case (state_q)
      F_IDLE: begin
        if (acc_i) begin
          if (!word_i.last_word) begin
            k_d = word_i.key_word;
            full_d = 1'b1;
            last_d = 1'b0;
            len_d = len_q + 16'd4;
            state_d = F_M1;
          end else begin
            act_d = word_i.action;
            last_d = 1'b1;
            full_d = (n == 3'd4);
            k_d = word_i.key_word & mask;
            len_d = len_q + 16'(n);
            state_d = (n == 3'd0) ? F_FIN1 : F_M1;
          end
        end
      end
      F_M1: begin
        k_d = 32'(k_q * fbf_pkg::C1);
        state_d = F_M2;
      end
      F_M2: begin
        k_d = 32'(kr * fbf_pkg::C2);
        state_d = F_M3;
      end
      F_M3: begin
        if (full_q) begin
          ha_d = (ra << 2) + ra + fbf_pkg::C3;
          hb_d = (rb << 2) + rb + fbf_pkg::C3;
        end else begin
          ha_d = ha_q ^ k_q;
          hb_d = hb_q ^ k_q;
        end
        state_d = last_q ? F_FIN1 : F_IDLE;
      end
      F_FIN1: begin
        ha_d = 32'(fa * fbf_pkg::C4);
        hb_d = 32'(fb * fbf_pkg::C4);
        state_d = F_FIN2;
      end
      F_FIN2: begin
        ha_d = 32'((ha_q ^ (ha_q >> 13)) * fbf_pkg::C5);
        hb_d = 32'((hb_q ^ (hb_q >> 13)) * fbf_pkg::C5);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready_i) begin
          ha_d = fbf_pkg::SEED_A;
          hb_d = fbf_pkg::SEED_B;
          len_d = 16'd0;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      ha_q <= fbf_pkg::SEED_A;
      hb_q <= fbf_pkg::SEED_B;
      len_q <= 16'd0;
    end else begin
      state_q <= state_d;
      ha_q <= ha_d;
      hb_q <= hb_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    act_q <= act_d;
    full_q <= full_d;
    last_q <= last_d;
  end

  assign ready_o = (state_q == F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o.action = act_q;
  assign job_o.ha = ha_q ^ (ha_q >> 16);
  assign job_o.hb = hb_q ^ (hb_q >> 16);
endmodule

// File: design/fbf_queue.sv
// Two-entry queue of finished hash jobs between front and back.
module fbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fbf_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fbf_pkg::job_t pop_data_o
);
  fbf_pkg::job_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end
endmodule

// File: design/fbf_back.sv
// Table walk back end: slot reduction, linear probing and result register.
module fbf_back #(
  parameter int CELLS = 4096,
  parameter int MAX_HASHES = 8,
  parameter int MAX_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fbf_pkg::job_t    job_i,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  fbf_pkg::cfg_t    cfg_i,
  output fbf_pkg::result_t res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic             clear_done_o
);
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + 1);
  localparam int PW = $clog2(MAX_HASHES + 1);
  localparam int RW = $clog2(MAX_STEPS + 1);

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_DIV, B_RD, B_CMP, B_NEXT, B_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d, idx_q, idx_d;
  logic [31:0]      x_q, x_d, hb_q, hb_d, total_q, total_d;
  logic [7:0]       fp_q, fp_d;
  logic             act_q, act_d, ok_q, ok_d;
  logic [PW-1:0]    path_q, path_d;
  logic [RW-1:0]    probe_q, probe_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [4:0]       bit_q, bit_d;
  fbf_pkg::result_t res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic [CW-1:0] cells_c;
  logic [PW-1:0] paths_c;
  logic [RW-1:0] probes_c;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata, rdata;

  always_comb begin
    if (cfg_i.cells == 13'd0) cells_c = CW'(1);
    else if (32'(cfg_i.cells) > CELLS) cells_c = CW'(CELLS);
    else cells_c = CW'(cfg_i.cells);
    if (cfg_i.hashes == 4'd0) paths_c = PW'(1);
    else if (32'(cfg_i.hashes) > MAX_HASHES) paths_c = PW'(MAX_HASHES);
    else paths_c = PW'(cfg_i.hashes);
    if (32'(cfg_i.probes) > MAX_STEPS) probes_c = RW'(MAX_STEPS);
    else probes_c = RW'(cfg_i.probes);
  end

  fbf_ram #(.Width(8), .Depth(CELLS)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    logic [CW:0]   rem_sh;
    logic [CW-1:0] rem_n, idx_inc;
    logic          hit, stop, good;
    state_d = state_q;
    clr_d = clr_q;
    idx_d = idx_q;
    x_d = x_q;
    hb_d = hb_q;
    total_d = total_q;
    fp_d = fp_q;
    act_d = act_q;
    ok_d = ok_q;
    path_d = path_q;
    probe_d = probe_q;
    rem_d = rem_q;
    bit_d = bit_q;
    res_d = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    we = 1'b0;
    waddr = idx_q;
    wdata = fp_q;
    good = 1'b0;
    stop = 1'b0;
    rem_sh = {rem_q, x_q[bit_q]};
    if (rem_sh >= {1'b0, cells_c}) rem_n = CW'(rem_sh - {1'b0, cells_c});
    else rem_n = CW'(rem_sh);
    idx_inc = CW'(idx_q) + CW'(1);
    hit = (rdata == fp_q);
    unique case (state_q)
      B_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        wdata = 8'd0;
        if (clr_q == AW'(CELLS - 1)) state_d = B_IDLE;
        else clr_d = clr_q + AW'(1);
      end
      B_IDLE: begin
        if (job_valid_i) begin
          x_d = job_i.ha;
          hb_d = job_i.hb;
          fp_d = (job_i.hb[7:0] == 8'd0) ? 8'd1 : job_i.hb[7:0];
          act_d = job_i.action;
          ok_d = 1'b1;
          path_d = '0;
          rem_d = '0;
          bit_d = 5'd31;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        rem_d = rem_n;
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          idx_d = AW'(rem_n);
          probe_d = '0;
          if (probes_c == '0) begin
            ok_d = 1'b0;
            state_d = B_NEXT;
          end else begin
            state_d = B_RD;
          end
        end
      end
      B_RD: state_d = B_CMP;
      B_CMP: begin
        good = hit || (act_q == fbf_pkg::ACT_INSERT && rdata == 8'd0);
        stop = good || rdata == 8'd0 || (probe_q + RW'(1) == probes_c);
        if (good && act_q == fbf_pkg::ACT_INSERT) we = 1'b1;
        if (stop) begin
          ok_d = ok_q && good;
          state_d = B_NEXT;
        end else begin
          probe_d = probe_q + RW'(1);
          idx_d = (idx_inc == cells_c) ? '0 : AW'(idx_inc);
          state_d = B_RD;
        end
      end
      B_NEXT: begin
        if ((path_q + PW'(1) == paths_c) || (act_q == fbf_pkg::ACT_CHECK && !ok_q)) begin
          state_d = B_FIN;
        end else begin
          path_d = path_q + PW'(1);
          x_d = x_q + hb_q;
          rem_d = '0;
          bit_d = 5'd31;
          state_d = B_DIV;
        end
      end
      B_FIN: begin
        if (!res_valid_d) begin
          if (act_q == fbf_pkg::ACT_INSERT) begin
            res_d.answer = ok_q ? fbf_pkg::ANS_INSERTED : fbf_pkg::ANS_FULL;
            if (ok_q && total_q != 32'hffffffff) total_d = total_q + 32'd1;
          end else begin
            res_d.answer = ok_q ? fbf_pkg::ANS_MAYBE : fbf_pkg::ANS_ABSENT;
          end
          res_d.element_count = total_d;
          res_valid_d = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q <= '0;
      total_q <= 32'd0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      total_q <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    x_q <= x_d;
    hb_q <= hb_d;
    fp_q <= fp_d;
    act_q <= act_d;
    ok_q <= ok_d;
    path_q <= path_d;
    probe_q <= probe_d;
    rem_q <= rem_d;
    bit_q <= bit_d;
    res_q <= res_d;
  end

  assign job_ready_o = (state_q == B_IDLE);
  assign res_o = res_q;
  assign res_valid_o = res_valid_q;
  assign clear_done_o = (state_q != B_CLEAR);
endmodule

// File: design/fingerprint_bloom_filter_top.sv
// Top level of the fingerprint Bloom filter.
//
//   channel  dir  payload                                     transfer
//   in_i     in   action, key_word, word_bytes, last_word     valid && ready
//   out_o    out  answer, element_count                       valid && ready
//   cfg_i    in   index, data                                 valid && ready
//
// A non-final key word passes front states F_M1 to F_M3; a final word passes these
// (skipped with no tail bytes), F_FIN1, F_FIN2 and F_PUSH until its job enters the
// queue, longer while the queue is full. Each probe path runs the serial remainder
// unit over every hash bit, then B_RD and B_CMP per table read and B_NEXT to move on;
// B_IDLE takes the job and B_FIN the result. After reset a clearing pass of all cells
// precedes the first key word. The queue lets the front hash while the back walks.
module fingerprint_bloom_filter_top #(
  parameter int CELLS = 4096,
  parameter int MAX_HASHES = 8,
  parameter int MAX_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fbf_in_if.sink       in_i,
  fbf_out_if.source    out_o,
  fbf_cfg_if.sink      cfg_i
);
  fbf_pkg::cfg_t    cfg_q;
  fbf_pkg::word_t   word;
  fbf_pkg::job_t    f_job, b_job;
  fbf_pkg::result_t res;
  logic front_ready, clear_done, in_acc;
  logic f_valid, f_ready, b_valid, b_ready, res_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cells <= 13'd4096;
      cfg_q.hashes <= 4'd4;
      cfg_q.probes <= 5'd8;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        fbf_pkg::REG_CELLS: cfg_q.cells <= cfg_i.data[12:0];
        fbf_pkg::REG_HASHES: cfg_q.hashes <= cfg_i.data[3:0];
        fbf_pkg::REG_PROBES: cfg_q.probes <= cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = front_ready && clear_done;
  assign in_acc = in_i.valid && in_i.ready;
  assign word.action = in_i.action;
  assign word.key_word = in_i.key_word;
  assign word.word_bytes = in_i.word_bytes;
  assign word.last_word = in_i.last_word;

  fbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .word_i      (word),
    .ready_o     (front_ready),
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready)
  );

  fbf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_job)
  );

  fbf_back #(
    .CELLS      (CELLS),
    .MAX_HASHES (MAX_HASHES),
    .MAX_STEPS  (MAX_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (b_job),
    .job_valid_i  (b_valid),
    .job_ready_o  (b_ready),
    .cfg_i        (cfg_q),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready),
    .clear_done_o (clear_done)
  );

  assign out_o.valid = res_valid;
  assign out_o.answer = res.answer;
  assign out_o.element_count = res.element_count;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !clear_done |-> !in_i.ready)
    else $error("Key word taken during the table clearing pass.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.answer == fbf_pkg::ANS_INSERTED) |-> (out_o.element_count != 32'd0))
    else $error("Successful insert reported with a zero element count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clear_done) |-> (!b_ready && !res_valid))
    else $error("Back end active before the table is cleared.");
endmodule

// File: tb/fingerprint_bloom_filter_top_test.sv
// Self-checking testbench of the fingerprint Bloom filter with directed and random key streams.
module fingerprint_bloom_filter_top_test;

  localparam int CELLS = 4096;
  localparam int MAX_HASHES = 8;
  localparam int MAX_STEPS = 16;
  localparam int DRAIN_CYCLES = 1200;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  answer;
    logic [31:0] count;
  } answer_t;

  typedef struct {
    logic        act;
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    bit          typed;
    logic [1:0]  answer;
    logic [31:0] count;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  fbf_in_if in_ch ();
  fbf_out_if out_ch ();
  fbf_cfg_if cfg_ch ();

  fingerprint_bloom_filter_top #(
    .CELLS(CELLS),
    .MAX_HASHES(MAX_HASHES),
    .MAX_STEPS(MAX_STEPS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch.sink),
    .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  logic [7:0]  fp_table [CELLS];
  logic [31:0] acc_a;
  logic [31:0] acc_b;
  logic [15:0] key_len;
  logic [31:0] insert_total;
  logic [12:0] cfg_cells;
  logic [3:0]  cfg_hashes;
  logic [4:0]  cfg_probes;

  answer_t pending_answers [$];
  int errors;
  bit no_gaps;

  logic [31:0] saved_words [16][8];
  int          saved_len [16];
  logic [2:0]  saved_tail [16];
  int          saved_num;
  int          sent_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100000000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_word(input logic [31:0] k);
    logic [31:0] t;
    t = k * fbf_pkg::C1;
    t = rotate_left(t, 15);
    return t * fbf_pkg::C2;
  endfunction

  function automatic logic [31:0] absorb_block(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = h ^ scramble_word(k);
    t = rotate_left(t, 13);
    return t * 32'd5 + fbf_pkg::C3;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h, input logic [15:0] len);
    logic [31:0] t;
    t = h ^ {16'd0, len};
    t = t ^ (t >> 16);
    t = t * fbf_pkg::C4;
    t = t ^ (t >> 13);
    t = t * fbf_pkg::C5;
    return t ^ (t >> 16);
  endfunction

  task automatic predict_word(input fbf_pkg::word_t w);
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] tail;
    logic [31:0] start;
    logic [7:0]  fp;
    logic [7:0]  cur;
    int nb;
    int cells;
    int paths;
    int probes;
    int idx;
    bit all_ok;
    bit hit;
    answer_t res;
    if (!w.last_word) begin
      acc_a = absorb_block(acc_a, w.key_word);
      acc_b = absorb_block(acc_b, w.key_word);
      key_len = key_len + 16'd4;
      return;
    end
    nb = (w.word_bytes > 3'd4) ? 4 : int'(w.word_bytes);
    if (nb == 4) begin
      acc_a = absorb_block(acc_a, w.key_word);
      acc_b = absorb_block(acc_b, w.key_word);
    end else if (nb > 0) begin
      tail = w.key_word & ((32'd1 << (8 * nb)) - 32'd1);
      acc_a = acc_a ^ scramble_word(tail);
      acc_b = acc_b ^ scramble_word(tail);
    end
    key_len = key_len + 16'(nb);
    ha = avalanche(acc_a, key_len);
    hb = avalanche(acc_b, key_len);
    acc_a = fbf_pkg::SEED_A;
    acc_b = fbf_pkg::SEED_B;
    key_len = '0;
    fp = (hb[7:0] == 8'd0) ? 8'd1 : hb[7:0];
    cells = (cfg_cells == 0) ? 1 : ((cfg_cells > CELLS) ? CELLS : int'(cfg_cells));
    paths = (cfg_hashes == 0) ? 1 : ((cfg_hashes > MAX_HASHES) ? MAX_HASHES : int'(cfg_hashes));
    probes = (cfg_probes > MAX_STEPS) ? MAX_STEPS : int'(cfg_probes);
    if (w.action == fbf_pkg::ACT_INSERT) begin
      all_ok = 1'b1;
      for (int i = 0; i < paths; i++) begin
        start = (ha + 32'(i) * hb) % 32'(cells);
        hit = 1'b0;
        for (int p = 0; p < probes && !hit; p++) begin
          idx = int'((start + 32'(p)) % 32'(cells));
          cur = fp_table[idx];
          if (cur == 8'd0 || cur == fp) begin
            fp_table[idx] = fp;
            hit = 1'b1;
          end
        end
        if (!hit) all_ok = 1'b0;
      end
      if (all_ok) begin
        if (insert_total != 32'hFFFFFFFF) insert_total++;
        res.answer = fbf_pkg::ANS_INSERTED;
      end else begin
        res.answer = fbf_pkg::ANS_FULL;
      end
    end else begin
      res.answer = fbf_pkg::ANS_MAYBE;
      for (int i = 0; i < paths && res.answer == fbf_pkg::ANS_MAYBE; i++) begin
        start = (ha + 32'(i) * hb) % 32'(cells);
        hit = 1'b0;
        for (int p = 0; p < probes; p++) begin
          cur = fp_table[int'((start + 32'(p)) % 32'(cells))];
          if (cur == fp) begin
            hit = 1'b1;
            break;
          end
          if (cur == 8'd0) break;
        end
        if (!hit) res.answer = fbf_pkg::ANS_ABSENT;
      end
    end
    res.count = insert_total;
    pending_answers.push_back(res);
  endtask

  task automatic send_word(input fbf_pkg::word_t w, input bit typed, input answer_t typed_res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= w.action;
    in_ch.key_word <= w.key_word;
    in_ch.word_bytes <= w.word_bytes;
    in_ch.last_word <= w.last_word;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_word(w);
    if (typed && w.last_word) pending_answers[pending_answers.size() - 1] = typed_res;
    sent_items++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    case (index)
      fbf_pkg::REG_CELLS:  cfg_cells = value[12:0];
      fbf_pkg::REG_HASHES: cfg_hashes = value[3:0];
      fbf_pkg::REG_PROBES: cfg_probes = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int cells, input int hashes, input int probes);
    wait_idle();
    write_reg(fbf_pkg::REG_CELLS, {19'($urandom_range(0, 32'h7FFFF)), 13'(cells)});
    write_reg(fbf_pkg::REG_HASHES, {28'($urandom_range(0, 32'hFFFFFFF)), 4'(hashes)});
    write_reg(fbf_pkg::REG_PROBES, {27'($urandom_range(0, 32'h7FFFFFF)), 5'(probes)});
  endtask

  task automatic send_key(input logic act);
    fbf_pkg::word_t w;
    answer_t none;
    int slot;
    int len;
    bit reuse;
    none = '0;
    reuse = (saved_num > 0) && ($urandom_range(0, 99) < 45);
    if (reuse) begin
      slot = $urandom_range(0, saved_num - 1);
    end else begin
      slot = (saved_num < 16) ? saved_num : $urandom_range(0, 15);
      if (saved_num < 16) saved_num++;
      len = $urandom_range(0, 99) < 10 ? $urandom_range(0, 7) : $urandom_range(0, 3);
      saved_len[slot] = len;
      saved_tail[slot] = 3'($urandom_range(0, 7));
      for (int i = 0; i <= len; i++) saved_words[slot][i] = $urandom;
    end
    for (int i = 0; i <= saved_len[slot]; i++) begin
      w.action = (i == saved_len[slot]) ? act : 1'($urandom);
      w.key_word = saved_words[slot][i];
      w.last_word = (i == saved_len[slot]);
      w.word_bytes = w.last_word ? saved_tail[slot]
                     : ($urandom_range(0, 3) == 0 ? 3'($urandom_range(0, 7)) : 3'd4);
      send_word(w, 1'b0, none);
    end
  endtask

  initial begin
    answer_t got;
    answer_t want;
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      got.answer = out_ch.answer;
      got.count = out_ch.element_count;
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected result answer=%0d count=%0d", got.answer, got.count));
      end else begin
        want = pending_answers.pop_front();
        if (got.answer !== want.answer)
          report($sformatf("answer %0d, expected %0d", got.answer, want.answer));
        if (got.count !== want.count)
          report($sformatf("element_count %0d, expected %0d", got.count, want.count));
      end
    end
  end

  stim_row_t rows [] = '{
    '{fbf_pkg::ACT_CHECK,  32'hDEADBEEF, 3'd4, 1'b0, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'h00000055, 3'd1, 1'b1, 1'b1, fbf_pkg::ANS_ABSENT,   32'd0},
    '{fbf_pkg::ACT_INSERT, 32'hDEADBEEF, 3'd4, 1'b0, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_INSERT, 32'h00000055, 3'd1, 1'b1, 1'b1, fbf_pkg::ANS_INSERTED, 32'd1},
    '{fbf_pkg::ACT_INSERT, 32'hDEADBEEF, 3'd4, 1'b0, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'h00000055, 3'd1, 1'b1, 1'b1, fbf_pkg::ANS_MAYBE,    32'd1},
    '{fbf_pkg::ACT_INSERT, 32'h00000000, 3'd0, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'h00000000, 3'd0, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_INSERT, 32'hFFFFFFFF, 3'd7, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_INSERT, 32'h12345678, 3'd0, 1'b0, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_INSERT, 32'hA5A5A5A5, 3'd3, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'h12345678, 3'd2, 1'b0, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'hA5A5A5A5, 3'd3, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_INSERT, 32'h80000001, 3'd2, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'h80000001, 3'd2, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0},
    '{fbf_pkg::ACT_CHECK,  32'h7FFFFFFE, 3'd6, 1'b1, 1'b0, fbf_pkg::ANS_INSERTED, 32'd0}
  };

  int phase_cells [7] = '{4096, 16, 0, 8191, 1, 300, 4096};
  int phase_hashes [7] = '{4, 2, 0, 15, 8, 1, 8};
  int phase_probes [7] = '{8, 3, 16, 31, 1, 0, 16};

  initial begin
    fbf_pkg::word_t w;
    answer_t typed_res;
    logic act;
    rst_ni = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= fbf_pkg::ACT_INSERT;
    in_ch.key_word <= '0;
    in_ch.word_bytes <= '0;
    in_ch.last_word <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= fbf_pkg::REG_CELLS;
    cfg_ch.data <= '0;
    errors = 0;
    no_gaps = 1'b0;
    saved_num = 0;
    sent_items = 0;
    for (int i = 0; i < CELLS; i++) fp_table[i] = 8'd0;
    acc_a = fbf_pkg::SEED_A;
    acc_b = fbf_pkg::SEED_B;
    key_len = '0;
    insert_total = '0;
    cfg_cells = 13'd4096;
    cfg_hashes = 4'd4;
    cfg_probes = 5'd8;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      w.action = rows[i].act;
      w.key_word = rows[i].word;
      w.word_bytes = rows[i].nbytes;
      w.last_word = rows[i].last;
      typed_res.answer = rows[i].answer;
      typed_res.count = rows[i].count;
      send_word(w, rows[i].typed, typed_res);
    end
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFFFFFF);

    for (int ph = 0; ph < 7; ph++) begin
      set_config(phase_cells[ph], phase_hashes[ph], phase_probes[ph]);
      saved_num = 0;
      while (sent_items < (ph + 1) * 280 + rows.size()) begin
        no_gaps = ($urandom_range(0, 9) == 0);
        act = ($urandom_range(0, 99) < 55) ? fbf_pkg::ACT_INSERT : fbf_pkg::ACT_CHECK;
        send_key(act);
        if (ph == 3 && sent_items % 100 < 4) begin
          in_ch.valid <= 1'b0;
          while (pending_answers.size() != 0) @(posedge clk_i);
        end
      end
      no_gaps = 1'b0;
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fbf_pkg.sv
design/fbf_if.sv
design/fbf_ram.sv
design/fbf_front.sv
design/fbf_queue.sv
design/fbf_back.sv
design/fingerprint_bloom_filter_top.sv
tb/fingerprint_bloom_filter_top_test.sv
